// ----- sv/mcld_pkg.sv -----
`timescale 1ns / 1ps
// Package for the two-box Diophantine solver.
// Holds the operation codes of the shared serial arithmetic unit; no dependencies.
package mcld_pkg;

    typedef enum logic [1:0] {
        OP_DIV = 2'd0,
        OP_MUL = 2'd1,
        OP_MOD = 2'd2
    } t_op;

endpackage

// ----- sv/mcld_serial_unit.sv -----
`timescale 1ns / 1ps
// Shared bit-serial arithmetic unit: restoring divide, shift-add multiply and
// modular multiply, one bit per cycle. Depends on mcld_pkg.
module mcld_serial_unit import mcld_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_op                i_op,
    input  logic [WIDTH-1:0]   i_x,
    input  logic [WIDTH-1:0]   i_y,
    input  logic [WIDTH-1:0]   i_m,
    output logic               o_done,
    output logic [WIDTH-1:0]   o_lo,
    output logic [WIDTH-1:0]   o_hi
);
    localparam int CW = $clog2(WIDTH);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    t_op                r_op;
    logic [WIDTH-1:0]   r_x;
    logic [WIDTH-1:0]   r_y;
    logic [WIDTH-1:0]   r_m;
    logic [2*WIDTH-1:0] r_acc;

    logic [2*WIDTH-1:0] n_acc;
    logic [WIDTH-1:0]   n_y;
    logic [WIDTH:0]     rem_sh, rem_sub, t1, t1r, t2, t2r;
    logic               ge;

    always_comb begin
        rem_sh  = {r_acc[WIDTH-1:0], r_y[WIDTH-1]};
        ge      = rem_sh >= {1'b0, r_m};
        rem_sub = ge ? rem_sh - {1'b0, r_m} : rem_sh;
        // modular: double, reduce, add, reduce
        t1  = {r_acc[WIDTH-1:0], 1'b0};
        t1r = (t1 >= {1'b0, r_m}) ? t1 - {1'b0, r_m} : t1;
        t2  = t1r + (r_y[WIDTH-1] ? {1'b0, r_x} : '0);
        t2r = (t2 >= {1'b0, r_m}) ? t2 - {1'b0, r_m} : t2;
        n_y = {r_y[WIDTH-2:0], 1'b0};
        case (r_op)
            OP_DIV: begin
                n_acc = {{WIDTH{1'b0}}, rem_sub[WIDTH-1:0]};
                n_y   = {r_y[WIDTH-2:0], ge};
            end
            OP_MUL: begin
                n_acc = {r_acc[2*WIDTH-2:0], 1'b0}
                      + (r_y[WIDTH-1] ? {{WIDTH{1'b0}}, r_x} : '0);
            end
            OP_MOD: begin
                n_acc = {{WIDTH{1'b0}}, t2r[WIDTH-1:0]};
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
                r_op   <= i_op;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= (i_op == OP_DIV) ? i_x : i_y;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy) begin
            r_y   <= n_y;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_lo   = (r_op == OP_DIV) ? r_y : r_acc[WIDTH-1:0];
    assign o_hi   = (r_op == OP_DIV) ? r_acc[WIDTH-1:0] : r_acc[2*WIDTH-1:WIDTH];

endmodule

// ----- sv/min_cost_linear_diophantine.sv -----
`timescale 1ns / 1ps
// Top level of the cheapest two-box exact-fill solver.
// Uses mcld_pkg and mcld_serial_unit.
//
// One transaction in gives total, and cost and capacity of two box kinds; one
// transaction out gives found and the two counts of the cheapest exact fill
// (both counts 0 when found is 0). Extended Euclid on the capacities gives the
// gcd g and Bezout coefficients; g must divide total, then the fewest boxes of
// kind one is taken when cost_one*cap_two >= cost_two*cap_one, else the fewest
// of kind two. All arithmetic runs through one bit-serial unit: each Euclid
// step is one divide and two multiplies (up to about 46 steps at WIDTH = 32),
// followed by up to thirteen more operations and one normalisation state.
// Input ready is high only while the block is idle; the result is held in
// output registers until taken.
module min_cost_linear_diophantine import mcld_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_total,
    input  logic [WIDTH-1:0] i_cost_one,
    input  logic [WIDTH-1:0] i_cap_one,
    input  logic [WIDTH-1:0] i_cost_two,
    input  logic [WIDTH-1:0] i_cap_two,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_found,
    output logic [WIDTH-1:0] o_count_one,
    output logic [WIDTH-1:0] o_count_two
);
    localparam int SW = WIDTH + 2;   // signed Bezout coefficients

    typedef enum logic [18:0] {
        S_IDLE   = 19'b0000000000000000001,
        S_E_DIV  = 19'b0000000000000000010,
        S_E_MS   = 19'b0000000000000000100,
        S_E_MT   = 19'b0000000000000001000,
        S_N_DIV  = 19'b0000000000000010000,
        S_A_DIV  = 19'b0000000000000100000,
        S_B_DIV  = 19'b0000000000001000000,
        S_NORM   = 19'b0000000000010000000,
        S_NQ_DIV = 19'b0000000000100000000,
        S_NX_DIV = 19'b0000000001000000000,
        S_XM     = 19'b0000000010000000000,
        S_XP_MUL = 19'b0000000100000000000,
        S_YH_DIV = 19'b0000001000000000000,
        S_YM     = 19'b0000010000000000000,
        S_YP_MUL = 19'b0000100000000000000,
        S_XH_DIV = 19'b0001000000000000000,
        S_C1_MUL = 19'b0010000000000000000,
        S_C2_MUL = 19'b0100000000000000000,
        S_DONE   = 19'b1000000000000000000
    } t_state;

    t_state           r_state;
    logic             r_go;
    logic [WIDTH-1:0] r_n, r_c1, r_a, r_c2, r_b;
    logic [WIDTH-1:0] r_r0, r_r1, r_q;
    logic [SW-1:0]    r_s0, r_s1, r_t0, r_t1;
    logic [WIDTH-1:0] r_np, r_ap, r_bp, r_xinv, r_yinv, r_u, r_npa, r_npr;
    logic [WIDTH-1:0] r_xlo, r_yhi, r_ylo, r_xhi, r_ph, r_pl;
    logic             r_found;
    logic [WIDTH-1:0] r_cnt1, r_cnt2;

    t_op              u_op;
    logic [WIDTH-1:0] u_x, u_y, u_m, u_lo, u_hi;
    logic             u_done;

    logic [SW-1:0]    s1_mag, t1_mag, prod_s, xv1, xv2, yv1, yv2;
    logic             low_first;

    mcld_serial_unit #(.WIDTH(WIDTH)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_op    (u_op),
        .i_x     (u_x),
        .i_y     (u_y),
        .i_m     (u_m),
        .o_done  (u_done),
        .o_lo    (u_lo),
        .o_hi    (u_hi)
    );

    // operand selection for the shared unit
    always_comb begin
        u_op = OP_DIV;
        u_x  = r_r0;
        u_y  = '0;
        u_m  = r_r1;
        case (r_state)
            S_E_MS:   begin u_op = OP_MUL; u_x = r_q;  u_y = s1_mag[WIDTH-1:0]; end
            S_E_MT:   begin u_op = OP_MUL; u_x = r_q;  u_y = t1_mag[WIDTH-1:0]; end
            S_N_DIV:  begin u_x = r_n;  u_m = r_r0; end
            S_A_DIV:  begin u_x = r_a;  u_m = r_r0; end
            S_B_DIV:  begin u_x = r_b;  u_m = r_r0; end
            S_NQ_DIV: begin u_x = r_np; u_m = r_ap; end
            S_NX_DIV: begin u_x = r_np; u_m = r_bp; end
            S_XM:     begin u_op = OP_MOD; u_x = r_u;   u_y = r_xinv; u_m = r_bp; end
            S_XP_MUL: begin u_op = OP_MUL; u_x = r_ap;  u_y = r_xlo; end
            S_YH_DIV: begin u_x = r_u;  u_m = r_bp; end
            S_YM:     begin u_op = OP_MOD; u_x = r_npr; u_y = r_yinv; u_m = r_ap; end
            S_YP_MUL: begin u_op = OP_MUL; u_x = r_bp;  u_y = r_ylo; end
            S_XH_DIV: begin u_x = r_u;  u_m = r_ap; end
            S_C1_MUL: begin u_op = OP_MUL; u_x = r_c1;  u_y = r_b; end
            S_C2_MUL: begin u_op = OP_MUL; u_x = r_c2;  u_y = r_a; end
            default:  begin u_op = OP_DIV; end
        endcase
    end

    always_comb begin
        s1_mag = r_s1[SW-1] ? -r_s1 : r_s1;
        t1_mag = r_t1[SW-1] ? -r_t1 : r_t1;
        // q*|coef| never exceeds twice the capacity: W+1 bits suffice
        prod_s = {1'b0, u_hi[0], u_lo};
        // bring the Bezout coefficients into [0, b/g) and [0, a/g)
        xv1 = r_s0[SW-1] ? r_s0 + SW'(r_bp) : r_s0;
        xv2 = (xv1 >= SW'(r_bp)) ? xv1 - SW'(r_bp) : xv1;
        yv1 = r_t0[SW-1] ? r_t0 + SW'(r_ap) : r_t0;
        yv2 = (yv1 >= SW'(r_ap)) ? yv1 - SW'(r_ap) : yv1;
        low_first = {r_ph, r_pl} >= {u_hi, u_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_cap_one == '0 || i_cap_two == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_E_DIV;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_E_DIV: if (u_done) begin r_state <= S_E_MS; r_go <= 1'b1; end
                S_E_MS:  if (u_done) begin r_state <= S_E_MT; r_go <= 1'b1; end
                S_E_MT: begin
                    if (u_done) begin
                        r_state <= (r_r1 == '0) ? S_N_DIV : S_E_DIV;
                        r_go    <= 1'b1;
                    end
                end
                S_N_DIV: begin
                    if (u_done) begin
                        if (u_hi != '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_A_DIV;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_A_DIV: if (u_done) begin r_state <= S_B_DIV; r_go <= 1'b1; end
                S_B_DIV: if (u_done) r_state <= S_NORM;
                S_NORM:   begin r_state <= S_NQ_DIV; r_go <= 1'b1; end
                S_NQ_DIV: if (u_done) begin r_state <= S_NX_DIV; r_go <= 1'b1; end
                S_NX_DIV: if (u_done) begin r_state <= S_XM; r_go <= 1'b1; end
                S_XM: begin
                    if (u_done) begin
                        if (u_lo > r_npa) begin
                            r_state <= S_DONE;   // no nonnegative solution
                        end else begin
                            r_state <= S_XP_MUL;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_XP_MUL: if (u_done) begin r_state <= S_YH_DIV; r_go <= 1'b1; end
                S_YH_DIV: if (u_done) begin r_state <= S_YM; r_go <= 1'b1; end
                S_YM:     if (u_done) begin r_state <= S_YP_MUL; r_go <= 1'b1; end
                S_YP_MUL: if (u_done) begin r_state <= S_XH_DIV; r_go <= 1'b1; end
                S_XH_DIV: if (u_done) begin r_state <= S_C1_MUL; r_go <= 1'b1; end
                S_C1_MUL: if (u_done) begin r_state <= S_C2_MUL; r_go <= 1'b1; end
                S_C2_MUL: if (u_done) r_state <= S_DONE;
                S_DONE:   if (i_ready) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n     <= i_total;
                r_c1    <= i_cost_one;
                r_a     <= i_cap_one;
                r_c2    <= i_cost_two;
                r_b     <= i_cap_two;
                r_r0    <= i_cap_one;
                r_r1    <= i_cap_two;
                r_s0    <= SW'(1);
                r_s1    <= '0;
                r_t0    <= '0;
                r_t1    <= SW'(1);
                r_found <= 1'b0;
                r_cnt1  <= '0;
                r_cnt2  <= '0;
            end
            S_E_DIV: if (u_done) begin
                r_q  <= u_lo;
                r_r0 <= r_r1;
                r_r1 <= u_hi;
            end
            S_E_MS: if (u_done) begin
                r_s0 <= r_s1;
                r_s1 <= r_s0 - (r_s1[SW-1] ? -prod_s : prod_s);
            end
            S_E_MT: if (u_done) begin
                r_t0 <= r_t1;
                r_t1 <= r_t0 - (r_t1[SW-1] ? -prod_s : prod_s);
            end
            S_N_DIV:  if (u_done) r_np <= u_lo;
            S_A_DIV:  if (u_done) r_ap <= u_lo;
            S_B_DIV:  if (u_done) r_bp <= u_lo;
            S_NORM: begin
                r_xinv <= xv2[WIDTH-1:0];
                r_yinv <= yv2[WIDTH-1:0];
            end
            S_NQ_DIV: if (u_done) begin
                r_npa <= u_lo;
                r_npr <= u_hi;
            end
            S_NX_DIV: if (u_done) r_u <= u_hi;
            S_XM:     if (u_done) r_xlo <= u_lo;
            S_XP_MUL: if (u_done) r_u <= r_np - u_lo;
            S_YH_DIV: if (u_done) r_yhi <= u_lo;
            S_YM:     if (u_done) r_ylo <= u_lo;
            S_YP_MUL: if (u_done) r_u <= r_np - u_lo;
            S_XH_DIV: if (u_done) r_xhi <= u_lo;
            S_C1_MUL: if (u_done) begin
                r_ph <= u_hi;
                r_pl <= u_lo;
            end
            S_C2_MUL: if (u_done) begin
                r_found <= 1'b1;
                r_cnt1  <= low_first ? r_xlo : r_xhi;
                r_cnt2  <= low_first ? r_yhi : r_ylo;
            end
            default: begin
                r_found <= r_found;
            end
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_DONE);
    assign o_found     = r_found;
    assign o_count_one = r_cnt1;
    assign o_count_two = r_cnt2;

endmodule

// ----- tb/tb_min_cost_linear_diophantine.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for min_cost_linear_diophantine.
// Depends on the block RTL. A directed table comes first, then random exact-fill
// problems. Each transaction is checked against its typed row or a behavioural solver.
module tb_min_cost_linear_diophantine;

    localparam int W          = 32;
    localparam int HALF       = 2;
    localparam int STALL_MAX  = 40000;   // idle cycles before the watchdog gives up
    localparam int DRAIN      = 6000;    // a bit over one worst-case item
    localparam int N_RANDOM   = 240;

    typedef struct packed {
        logic         found;
        logic [W-1:0] count_one;
        logic [W-1:0] count_two;
    } t_fill;

    typedef struct {
        logic [W-1:0] total, cost_one, cap_one, cost_two, cap_two;
        bit           typed;   // expected value written into the row
        t_fill        want;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_ready;
    logic [W-1:0] i_total = '0, i_cost_one = '0, i_cap_one = '0;
    logic [W-1:0] i_cost_two = '0, i_cap_two = '0;
    logic         o_valid;
    logic         i_ready = 1'b0;
    logic         o_found;
    logic [W-1:0] o_count_one, o_count_two;

    t_fill pending_fills[$];
    int    n_errors = 0;
    int    idle_pct = 0;      // sender gap probability, per cent
    int    stall_pct = 0;     // receiver stall probability, per cent
    int    quiet_cycles = 0;

    always #HALF i_clk = ~i_clk;

    min_cost_linear_diophantine #(.WIDTH(W)) DUT (.*);

    // Behavioural solver: extended Euclid on the capacities, then the cheaper end
    // of the range of nonnegative solutions.
    function automatic t_fill cheapest_fill(logic [W-1:0] n_in, c1_in, a_in, c2_in, b_in);
        t_fill      f;
        longint     r0, r1, s0, s1, t0, t1, q, tmp, rem;
        bit [63:0]  n, a, b, g, ap, bp, np, xinv, yinv, x_lo, y_lo, x_hi, y_hi, pc1, pc2;
        f = '0;
        n = n_in; a = a_in; b = b_in;
        if (a == 0 || b == 0)
            return f;
        r0 = longint'(a); r1 = longint'(b);
        s0 = 1; s1 = 0; t0 = 0; t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            tmp = r0 - q * r1; r0 = r1; r1 = tmp;
            tmp = s0 - q * s1; s0 = s1; s1 = tmp;
            tmp = t0 - q * t1; t0 = t1; t1 = tmp;
        end
        g = r0;
        if (n % g != 0)
            return f;
        ap = a / g; bp = b / g; np = n / g;
        rem = s0 % longint'(bp); if (rem < 0) rem += longint'(bp); xinv = rem;
        rem = t0 % longint'(ap); if (rem < 0) rem += longint'(ap); yinv = rem;
        // operands stay below 2^32, so the products fit in 64 bits
        x_lo = (np * xinv) % bp;
        if (x_lo > np / ap)
            return f;
        y_hi = (np - ap * x_lo) / bp;
        y_lo = (np * yinv) % ap;
        x_hi = (np - bp * y_lo) / ap;
        pc1 = 64'(c1_in) * b;
        pc2 = 64'(c2_in) * a;
        f.found = 1'b1;
        if (pc1 >= pc2) begin
            f.count_one = x_lo[W-1:0]; f.count_two = y_hi[W-1:0];
        end else begin
            f.count_one = x_hi[W-1:0]; f.count_two = y_lo[W-1:0];
        end
        return f;
    endfunction

    // Receiver: ready toggled at the falling edge by the current stall rate.
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result check at the rising edge.
    always @(posedge i_clk) begin
        t_fill got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_found, o_count_one, o_count_two};
            if (pending_fills.size() == 0) begin
                $display("%0t: unexpected transaction found=%0d c1=%0d c2=%0d",
                         $time, got.found, got.count_one, got.count_two);
                n_errors++;
            end else begin
                want = pending_fills.pop_front();
                if (got.found !== want.found) begin
                    $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
                    n_errors++;
                end
                if (got.count_one !== want.count_one) begin
                    $display("%0t: count_one expected %0d actual %0d",
                             $time, want.count_one, got.count_one);
                    n_errors++;
                end
                if (got.count_two !== want.count_two) begin
                    $display("%0t: count_two expected %0d actual %0d",
                             $time, want.count_two, got.count_two);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("tb_min_cost_linear_diophantine: FAIL");
            $finish;
        end
    end

    // Drives one problem: optional gap, then valid held until accepted.
    task automatic send_problem(t_row r);
        t_fill want;
        while ($urandom_range(99) < idle_pct)
            @(negedge i_clk);
        i_total = r.total; i_cost_one = r.cost_one; i_cap_one = r.cap_one;
        i_cost_two = r.cost_two; i_cap_two = r.cap_two;
        i_valid = 1'b1;
        want = r.typed ? r.want : cheapest_fill(r.total, r.cost_one, r.cap_one,
                                                r.cost_two, r.cap_two);
        do @(posedge i_clk); while (!o_ready);
        pending_fills.push_back(want);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic logic [W-1:0] rnd_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(40, 1);
            2: return $urandom_range(32'hFFFF, 1);
            default: return 32'hFFFF_FFFF - $urandom_range(3);
        endcase
    endfunction

    // Random problem, mostly built so that a nonnegative fill exists.
    function automatic t_row rnd_problem();
        t_row       r;
        bit [63:0]  sum;
        logic [W-1:0] k;
        r.typed = 1'b0; r.want = '0;
        r.cost_one = rnd_word(); r.cost_two = rnd_word();
        case ($urandom_range(3))
            0: begin
                r.total = $urandom(); r.cap_one = $urandom(); r.cap_two = $urandom();
            end
            1: begin  // common factor in the capacities
                k = $urandom_range(12, 1);
                r.cap_one = k * $urandom_range(500, 1);
                r.cap_two = k * $urandom_range(500, 1);
                r.total   = $urandom_range(20000, 1);
            end
            default: begin  // total built from real counts
                r.cap_one = rnd_word(); r.cap_two = rnd_word();
                sum = 64'(r.cap_one) * $urandom_range(300)
                    + 64'(r.cap_two) * $urandom_range(300);
                r.total = (sum == 0 || sum[63:W] != 0) ? r.cap_one : sum[W-1:0];
            end
        endcase
        return r;
    endfunction

    localparam logic [W-1:0] MAXW = '1;

    // Directed rows; expectations typed only where obvious.
    t_row directed[] = '{
        '{10, 1, 0, 1, 5, 1'b1, t_fill'{1'b0, '0, '0}},        // zero capacity, first kind
        '{10, 1, 5, 1, 0, 1'b1, t_fill'{1'b0, '0, '0}},        // zero capacity, second kind
        '{0, 1, 3, 1, 5, 1'b1, t_fill'{1'b1, '0, '0}},         // nothing to pack
        '{7, 1, 4, 1, 6, 1'b1, t_fill'{1'b0, '0, '0}},         // gcd does not divide total
        '{1, 1, 2, 1, 3, 1'b1, t_fill'{1'b0, '0, '0}},         // divisible but no nonnegative fill
        '{MAXW, MAXW, MAXW, MAXW, MAXW, 1'b1, t_fill'{1'b1, '0, 32'd1}},
        '{MAXW, 1, 1, 2, 1, 1'b1, t_fill'{1'b1, MAXW, '0}},    // kind one cheaper
        '{MAXW, 2, 1, 1, 1, 1'b1, t_fill'{1'b1, '0, MAXW}},    // kind two cheaper
        '{0, 0, 7, 0, 9, 1'b1, t_fill'{1'b1, '0, '0}},         // zero costs
        '{100, 3, 7, 5, 11, 1'b0, t_fill'('0)},
        '{100, 5, 7, 3, 11, 1'b0, t_fill'('0)},
        '{1000, 1, 6, 1, 10, 1'b0, t_fill'('0)},
        '{MAXW, 1, MAXW - 1, 1, 2, 1'b0, t_fill'('0)},
        '{MAXW - 1, 9, 32'h8000_0001, 4, 32'h7FFF_FFFF, 1'b0, t_fill'('0)},
        '{32'hFFFF_FFF0, MAXW, 32'hAAAA_AAAA, 1, 32'h5555_5555, 1'b0, t_fill'('0)},
        '{32'h1234_5678, 1, 32'hFFFF_FFFB, MAXW, 32'hFFFF_FFFD, 1'b0, t_fill'('0)},
        '{832040, 1, 832040, 1, 514229, 1'b0, t_fill'('0)},     // Fibonacci pair: long Euclid
        '{32'hB11924E1, 7, 32'hB11924E1, 3, 32'h6D73E55F, 1'b0, t_fill'('0)},
        '{1, 1, 1, 1, 1, 1'b0, t_fill'('0)}
    };

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i])
            send_problem(directed[i]);

        // hold off until the block has drained
        while (pending_fills.size() != 0)
            @(negedge i_clk);

        // phases: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            for (int k = 0; k < N_RANDOM / 4; k++)
                send_problem(rnd_problem());
        end

        stall_pct = 0;
        while (pending_fills.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (n_errors == 0 && pending_fills.size() == 0)
            $display("tb_min_cost_linear_diophantine: PASS");
        else
            $display("tb_min_cost_linear_diophantine: FAIL");
        $finish;
    end

endmodule

// ----- min_cost_linear_diophantine.f -----
sv/mcld_pkg.sv
sv/mcld_serial_unit.sv
sv/min_cost_linear_diophantine.sv
tb/tb_min_cost_linear_diophantine.sv
